// ===== sv/rrss_pkg.sv =====
// ----------------------------------------------------------------------------
// rrss_pkg
// Types and constants shared by the round-robin slice scheduler modules.
// ----------------------------------------------------------------------------
package rrss_pkg;

  // Field widths fixed by the command and result formats.
  localparam int unsigned TIME_BITS = 16;  // arrival, burst and quantum
  localparam int unsigned TIME_W    = 22;  // current time and per-process times
  localparam int unsigned TOTAL_W   = 27;  // running totals
  localparam int unsigned PID_W     = 6;
  localparam int unsigned CMD_W     = 2;

  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Command codes. Code 3 is unused and ignored.
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] burst_time;
  } cmd_item_t;

  typedef struct packed {
    logic               status;
    logic [PID_W-1:0]   process_id;
    logic [TIME_W-1:0]  slice_end_time;
    logic               finished;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TOTAL_W-1:0] total_turnaround;
    logic [TOTAL_W-1:0] total_waiting;
  } result_t;

  // One row of the process table.
  typedef struct packed {
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] remaining;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_init;
    logic wrap;
    logic skip;
    logic take;
    logic run;
    logic calc_tat;
    logic calc_wait;
    logic add_wait;
    logic emit_idle;
    logic emit_slice;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending;   // some loaded process still has work left
    logic at_end;    // scan position is past the last loaded entry
    logic eligible;  // entry under the scan position may run now
    logic done;      // the slice just taken completes its process
  } dp_status_t;

endpackage

// ===== sv/round_robin_slice_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_unit
// Round-robin scheduler over a table of processes with arrival times.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      in_data_i (cmd_item_t)
// result    out        result_valid_o, one cycle      result_o (result_t)
// config    in         cfg_valid_i and cfg_ready_o    cfg_data_i (quantum)
//
// A load or clear command leaves the block idle, so it takes the next command
// in the following cycle. An advance keeps busy high while the scan examines
// table entries one at a time, starting at the saved scan position, and wraps
// at the end of each pass; a slice that does not finish its process then runs
// and is emitted, while one that does also computes its turnaround, its waiting
// time and the totals first. The scan covers at most the rest of the current
// pass, one full pass that runs nothing, and a third pass up to the earliest
// arrival, each entry read through the single read port of the process table.
// The result appears in the cycle after its last step.
// When no process has work left, the advance answers without raising busy.
// Reset clears counts, time, totals and the scan state; the table itself is
// not cleared and needs no sweep. The receiver cannot stall results, so each
// result is shown for exactly one cycle and the block never waits on it.
//
module round_robin_slice_scheduler_unit #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rrss_pkg::cmd_item_t             in_data_i,
  output logic                            result_valid_o,
  output rrss_pkg::result_t               result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rrss_pkg::TIME_BITS-1:0]  cfg_data_i
);

  rrss_pkg::ctrl_cmd_t  ctrl_cmd;
  rrss_pkg::dp_status_t dp_status;
  logic                 cfg_we;

  // The quantum is only taken while no command is in progress.
  assign cfg_ready_o = ~busy;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // The controller decodes the command and walks the scan; it sees only the
  // status flags of the datapath.
  rrss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (in_data_i.cmd),
    .status_i       (dp_status),
    .cmd_o          (ctrl_cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // The datapath holds the table, the clock of the schedule, the totals and
  // the result register that stays stable while the strobe is high.
  rrss_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (ctrl_cmd),
    .status_o   (dp_status),
    .result_o   (result_o)
  );

  // Loads, clears and unused codes never keep the block busy.
  a_short_cmd_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_data_i.cmd != rrss_pkg::CMD_ADVANCE)) |=> !busy)
    else $error("short command left the block busy");

  // An idle answer names no process and finishes nothing.
  a_idle_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status) |->
      ((result_o.process_id == '0) && !result_o.finished))
    else $error("idle result carries a process");

  // A slice result always follows a busy cycle of the scan.
  a_slice_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.status) |-> $past(busy))
    else $error("slice result without a preceding scan");

endmodule

// ===== sv/rrss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer for the scheduler: decodes commands and steps the table scan.
// ----------------------------------------------------------------------------
module rrss_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [rrss_pkg::CMD_W-1:0]    cmd_i,
  input  rrss_pkg::dp_status_t          status_i,
  output rrss_pkg::ctrl_cmd_t           cmd_o,
  output logic                          busy,
  output logic                          result_valid_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_RUN  = 7'b0000100,
    ST_TAT  = 7'b0001000,
    ST_WAIT = 7'b0010000,
    ST_TOT  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q, strobe_d;

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = strobe_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            rrss_pkg::CMD_LOAD:  cmd_o.load  = 1'b1;
            rrss_pkg::CMD_CLEAR: cmd_o.clear = 1'b1;
            rrss_pkg::CMD_ADVANCE: begin
              if (status_i.pending) begin
                cmd_o.scan_init = 1'b1;
                state_d         = ST_SCAN;
              end else begin
                cmd_o.emit_idle = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.at_end) begin
          cmd_o.wrap = 1'b1;
        end else if (status_i.eligible) begin
          cmd_o.take = 1'b1;
          state_d    = ST_RUN;
        end else begin
          cmd_o.skip = 1'b1;
        end
      end
      ST_RUN: begin
        cmd_o.run = 1'b1;
        state_d   = status_i.done ? ST_TAT : ST_EMIT;
      end
      ST_TAT: begin
        cmd_o.calc_tat = 1'b1;
        state_d        = ST_WAIT;
      end
      ST_WAIT: begin
        cmd_o.calc_wait = 1'b1;
        state_d         = ST_TOT;
      end
      ST_TOT: begin
        cmd_o.add_wait = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_slice = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign strobe_d = cmd_o.emit_idle | cmd_o.emit_slice;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

endmodule

// ===== sv/rrss_datapath.sv =====
// ----------------------------------------------------------------------------
// rrss_datapath
// Process table, time keeping, slice arithmetic and the result register.
// ----------------------------------------------------------------------------
module rrss_datapath #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrss_pkg::TIME_BITS-1:0]  cfg_data_i,
  input  rrss_pkg::cmd_item_t             in_data_i,
  input  rrss_pkg::ctrl_cmd_t             cmd_i,
  output rrss_pkg::dp_status_t            status_o,
  output rrss_pkg::result_t               result_o
);

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCS);
  localparam int unsigned TB  = rrss_pkg::TIME_BITS;
  localparam int unsigned TW  = rrss_pkg::TIME_W;
  localparam int unsigned TOW = rrss_pkg::TOTAL_W;

  // Process table; no reset, only entries below the load count are used.
  rrss_pkg::entry_t mem [MAX_PROCS];
  rrss_pkg::entry_t rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  rrss_pkg::entry_t mem_wdata;

  // Control state.
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [TW-1:0]    time_q, time_d;
  logic             ran_q, ran_d;
  logic [TB-1:0]    pmin_q, pmin_d;
  logic [TOW-1:0]   sum_tat_q, sum_tat_d;
  logic [TOW-1:0]   sum_wt_q, sum_wt_d;
  logic [TB-1:0]    quant_q;

  // Payload of the slice in flight.
  rrss_pkg::entry_t ent_q, ent_d;
  logic [IDX_W-1:0] sel_q, sel_d;
  logic [TB-1:0]    run_q, run_d;
  logic             done_q, done_d;
  logic [TW-1:0]    tat_q, tat_d;
  logic [TW-1:0]    wt_q, wt_d;
  rrss_pkg::result_t res_q, res_d;

  logic [TW:0]      time_sum;
  logic [TOW:0]     tat_total;
  logic [TOW:0]     wt_total;
  logic [TW-1:0]    burst_ext;
  logic [IDX_W:0]   pid_full;

  assign time_sum  = {1'b0, time_q} + (TW + 1)'(run_q);
  assign tat_total = {1'b0, sum_tat_q} + (TOW + 1)'(tat_q);
  assign wt_total  = {1'b0, sum_wt_q} + (TOW + 1)'(wt_q);
  assign burst_ext = TW'(ent_q.burst);
  assign pid_full  = {1'b0, sel_q} + (IDX_W + 1)'(1);

  assign status_o.pending  = (pend_q != '0);
  assign status_o.at_end   = (pos_q >= count_q);
  assign status_o.eligible = (rdata_q.remaining != '0) && (TW'(rdata_q.arrival) <= time_q);
  assign status_o.done     = done_q;
  assign result_o          = res_q;

  always_comb begin
    count_d   = count_q;
    pend_d    = pend_q;
    pos_d     = pos_q;
    time_d    = time_q;
    ran_d     = ran_q;
    pmin_d    = pmin_q;
    sum_tat_d = sum_tat_q;
    sum_wt_d  = sum_wt_q;
    ent_d     = ent_q;
    sel_d     = sel_q;
    run_d     = run_q;
    done_d    = done_q;
    tat_d     = tat_q;
    wt_d      = wt_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = sel_q;
    mem_wdata = ent_q;

    if (cmd_i.clear) begin
      count_d   = '0;
      pend_d    = '0;
      pos_d     = '0;
      time_d    = '0;
      ran_d     = 1'b0;
      pmin_d    = '1;
      sum_tat_d = '0;
      sum_wt_d  = '0;
    end

    if (cmd_i.load && (count_q < MAX_CNT)) begin
      mem_we              = 1'b1;
      mem_waddr           = count_q[IDX_W-1:0];
      mem_wdata.arrival   = in_data_i.arrival_time;
      mem_wdata.burst     = in_data_i.burst_time;
      mem_wdata.remaining = in_data_i.burst_time;
      count_d             = count_q + CNT_W'(1);
      if (in_data_i.burst_time != '0) begin
        pend_d = pend_q + CNT_W'(1);
      end
    end

    if (cmd_i.scan_init) begin
      pmin_d = '1;
    end

    // End of a pass: a pass that ran nothing jumps to the earliest arrival.
    // Arrivals are narrower than the time, so the jump never saturates.
    if (cmd_i.wrap) begin
      if (!ran_q && (TW'(pmin_q) > time_q)) begin
        time_d = TW'(pmin_q);
      end
      ran_d  = 1'b0;
      pos_d  = '0;
      pmin_d = '1;
    end

    if (cmd_i.skip) begin
      pos_d = pos_q + CNT_W'(1);
      if ((rdata_q.remaining != '0) && (rdata_q.arrival < pmin_q)) begin
        pmin_d = rdata_q.arrival;
      end
    end

    if (cmd_i.take) begin
      sel_d  = pos_q[IDX_W-1:0];
      pos_d  = pos_q + CNT_W'(1);
      ran_d  = 1'b1;
      ent_d  = rdata_q;
      run_d  = (rdata_q.remaining > quant_q) ? quant_q : rdata_q.remaining;
      done_d = (rdata_q.remaining <= quant_q);
    end

    if (cmd_i.run) begin
      mem_we              = 1'b1;
      mem_waddr           = sel_q;
      mem_wdata           = ent_q;
      mem_wdata.remaining = ent_q.remaining - run_q;
      time_d              = time_sum[TW] ? rrss_pkg::TIME_MAX : time_sum[TW-1:0];
      if (done_q) begin
        pend_d = pend_q - CNT_W'(1);
      end
    end

    if (cmd_i.calc_tat) begin
      tat_d = time_q - TW'(ent_q.arrival);
    end

    if (cmd_i.calc_wait) begin
      wt_d      = (tat_q >= burst_ext) ? (tat_q - burst_ext) : '0;
      sum_tat_d = tat_total[TOW] ? rrss_pkg::TOTAL_MAX : tat_total[TOW-1:0];
    end

    if (cmd_i.add_wait) begin
      sum_wt_d = wt_total[TOW] ? rrss_pkg::TOTAL_MAX : wt_total[TOW-1:0];
    end

    if (cmd_i.emit_idle) begin
      res_d.status           = 1'b1;
      res_d.process_id       = '0;
      res_d.slice_end_time   = time_q;
      res_d.finished         = 1'b0;
      res_d.turnaround       = '0;
      res_d.waiting          = '0;
      res_d.total_turnaround = sum_tat_q;
      res_d.total_waiting    = sum_wt_q;
    end

    if (cmd_i.emit_slice) begin
      res_d.status           = 1'b0;
      res_d.process_id       = rrss_pkg::PID_W'(pid_full);
      res_d.slice_end_time   = time_q;
      res_d.finished         = done_q;
      res_d.turnaround       = done_q ? tat_q : '0;
      res_d.waiting          = done_q ? wt_q : '0;
      res_d.total_turnaround = sum_tat_q;
      res_d.total_waiting    = sum_wt_q;
    end
  end

  // The read address follows the next scan position, so the registered read
  // data holds the entry under the current scan position whenever it is inside the table.
  assign mem_raddr = (pos_d < MAX_CNT) ? pos_d[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pend_q    <= '0;
      pos_q     <= '0;
      time_q    <= '0;
      ran_q     <= 1'b0;
      pmin_q    <= '1;
      sum_tat_q <= '0;
      sum_wt_q  <= '0;
      quant_q   <= TB'(1);
    end else begin
      count_q   <= count_d;
      pend_q    <= pend_d;
      pos_q     <= pos_d;
      time_q    <= time_d;
      ran_q     <= ran_d;
      pmin_q    <= pmin_d;
      sum_tat_q <= sum_tat_d;
      sum_wt_q  <= sum_wt_d;
      if (cfg_we_i) begin
        // A quantum of zero behaves as one.
        quant_q <= (cfg_data_i == '0) ? TB'(1) : cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    sel_q  <= sel_d;
    run_q  <= run_d;
    done_q <= done_d;
    tat_q  <= tat_d;
    wt_q   <= wt_d;
    res_q  <= res_d;
  end

endmodule
